[rtl/core/ffha_pkg.sv]
package ffha_pkg;

    localparam int POOL_BYTES   = 4194304;
    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 24;
    localparam int SPLIT_SLACK  = 16;

    localparam int OFF_W  = 22;
    localparam int SIZE_W = 23;
    localparam int RND_W  = SIZE_W + 1;
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_ZERO    = 2'd3;

    // controller states, also sent to the datapath as the phase command
    localparam logic [3:0] PH_INIT      = 4'd0;
    localparam logic [3:0] PH_IDLE      = 4'd1;
    localparam logic [3:0] PH_SCAN      = 4'd2;
    localparam logic [3:0] PH_SHIFT     = 4'd3;
    localparam logic [3:0] PH_ALLOC_WR  = 4'd4;
    localparam logic [3:0] PH_SPLIT_HI  = 4'd5;
    localparam logic [3:0] PH_MERGE     = 4'd6;
    localparam logic [3:0] PH_MERGE_END = 4'd7;
    localparam logic [3:0] PH_RESULT    = 4'd8;

    typedef struct packed {
        logic [OFF_W-1:0]  start;
        logic [SIZE_W-1:0] bytes;
        logic              free;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [3:0] phase;
    } t_ctl_cmd;

    typedef struct packed {
        logic             req_zero;
        logic             is_alloc;
        logic             hit;
        logic             split_now;
        logic             split;
        logic             scan_end;
        logic             shift_end;
        logic             out_free;
        logic [CNT_W-1:0] count;
    } t_dp_sts;

endpackage

[rtl/core/ffha_if.sv]
interface ffha_req_if;
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic [ffha_pkg::SIZE_W-1:0] request_size;
    logic [ffha_pkg::OFF_W-1:0]  free_offset;

    modport source (output valid, output command, output request_size, output free_offset,
                    input ready);
    modport sink (input valid, input command, input request_size, input free_offset,
                  output ready);
endinterface

interface ffha_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [ffha_pkg::OFF_W-1:0] result_offset;

    modport source (output valid, output status, output result_offset, input ready);
    modport sink (input valid, input status, input result_offset, output ready);
endinterface

[rtl/core/first_fit_heap_allocator.sv]
// First-fit heap allocator over a 4 MiB pool kept as an address-ordered table of up to
// 64 blocks in one single-port-read RAM. One request at a time: an allocate scans the
// table entry by entry, and a split adds a shift of the entries above the chosen one
// and two writes; a free scans for the offset, then runs one streaming compaction pass
// that merges adjacent free blocks. The table RAM takes one read and one write per
// cycle. After reset the table seeds its first entry, one free block over the whole
// pool, before the first request is taken. A finished result waits in an output
// register, and the next request is taken while it waits.
module first_fit_heap_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffha_req_if.sink    i_req,
    ffha_rsp_if.source  o_rsp
);
    ffha_pkg::t_ctl_cmd w_cmd;
    ffha_pkg::t_dp_sts  w_sts;
    logic               w_ready;
    logic               w_accept;

    assign i_req.ready = w_ready;
    assign w_accept    = i_req.valid && w_ready;

    ffha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_ready (w_ready)
    );

    ffha_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_accept       (w_accept),
        .i_command      (i_req.command),
        .i_request_size (i_req.request_size),
        .i_free_offset  (i_req.free_offset),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_status       (o_rsp.status),
        .o_result_offset(o_rsp.result_offset),
        .o_sts          (w_sts)
    );

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_sts.count != '0) &&
        (w_sts.count <= ffha_pkg::CNT_W'(ffha_pkg::MAX_BLOCKS)))
        else $error("block count out of range");

    a_hit_end_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_sts.hit && w_sts.scan_end))
        else $error("scan hit and scan end together");

    a_null_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ffha_pkg::ST_DONE) |-> (o_rsp.result_offset == '0))
        else $error("nonzero offset on failed request");
endmodule

[rtl/core/ffha_ram.sv]
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/ffha_ctrl.sv]
module ffha_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  ffha_pkg::t_dp_sts i_sts,
    output ffha_pkg::t_ctl_cmd o_cmd,
    output logic              o_ready
);
    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ffha_pkg::PH_INIT: n_state = ffha_pkg::PH_IDLE;
            ffha_pkg::PH_IDLE: begin
                if (i_accept) begin
                    n_state = i_sts.req_zero ? ffha_pkg::PH_RESULT : ffha_pkg::PH_SCAN;
                end
            end
            ffha_pkg::PH_SCAN: begin
                if (i_sts.hit) begin
                    if (!i_sts.is_alloc) begin
                        n_state = ffha_pkg::PH_MERGE;
                    end else if (i_sts.split_now) begin
                        n_state = ffha_pkg::PH_SHIFT;
                    end else begin
                        n_state = ffha_pkg::PH_ALLOC_WR;
                    end
                end else if (i_sts.scan_end) begin
                    n_state = ffha_pkg::PH_RESULT;
                end
            end
            ffha_pkg::PH_SHIFT: begin
                if (i_sts.shift_end) begin
                    n_state = ffha_pkg::PH_ALLOC_WR;
                end
            end
            ffha_pkg::PH_ALLOC_WR: begin
                n_state = i_sts.split ? ffha_pkg::PH_SPLIT_HI : ffha_pkg::PH_RESULT;
            end
            ffha_pkg::PH_SPLIT_HI: n_state = ffha_pkg::PH_RESULT;
            ffha_pkg::PH_MERGE: begin
                if (i_sts.scan_end) begin
                    n_state = ffha_pkg::PH_MERGE_END;
                end
            end
            ffha_pkg::PH_MERGE_END: n_state = ffha_pkg::PH_RESULT;
            ffha_pkg::PH_RESULT: begin
                if (i_sts.out_free) begin
                    n_state = ffha_pkg::PH_IDLE;
                end
            end
            default: n_state = ffha_pkg::PH_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffha_pkg::PH_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.phase = r_state;
    assign o_ready     = (r_state == ffha_pkg::PH_IDLE);
endmodule

[rtl/core/ffha_dp.sv]
module ffha_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ffha_pkg::t_ctl_cmd              i_cmd,
    input  logic                            i_accept,
    input  logic                            i_command,
    input  logic [ffha_pkg::SIZE_W-1:0]     i_request_size,
    input  logic [ffha_pkg::OFF_W-1:0]      i_free_offset,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [1:0]                      o_status,
    output logic [ffha_pkg::OFF_W-1:0]      o_result_offset,
    output ffha_pkg::t_dp_sts               o_sts
);
    localparam logic [ffha_pkg::RND_W-1:0] ALIGN = ffha_pkg::RND_W'(7);
    localparam logic [ffha_pkg::RND_W:0] SPLIT_ADD =
        (ffha_pkg::RND_W+1)'(ffha_pkg::HEADER_BYTES + ffha_pkg::SPLIT_SLACK);
    localparam logic [ffha_pkg::SIZE_W-1:0] HDR = ffha_pkg::SIZE_W'(ffha_pkg::HEADER_BYTES);
    localparam logic [ffha_pkg::CNT_W-1:0] CNT_MAX = ffha_pkg::CNT_W'(ffha_pkg::MAX_BLOCKS);

    logic                         r_cmd;
    logic [ffha_pkg::RND_W-1:0]   r_size;
    logic [ffha_pkg::OFF_W-1:0]   r_off;
    logic [ffha_pkg::CNT_W-1:0]   r_rd;
    logic                         r_chk_vld;
    logic [ffha_pkg::IDX_W-1:0]   r_chk_idx;
    logic [ffha_pkg::IDX_W-1:0]   r_hit_idx;
    ffha_pkg::t_entry             r_hit_ent;
    logic                         r_split;
    logic [ffha_pkg::IDX_W-1:0]   r_wr;
    ffha_pkg::t_entry             r_pend;
    logic                         r_pend_vld;
    logic [ffha_pkg::CNT_W-1:0]   r_count;
    logic [1:0]                   r_res_status;
    logic [ffha_pkg::OFF_W-1:0]   r_res_off;
    logic                         r_out_vld;
    logic [1:0]                   r_out_status;
    logic [ffha_pkg::OFF_W-1:0]   r_out_off;

    logic                         w_we;
    logic [ffha_pkg::IDX_W-1:0]   w_waddr;
    ffha_pkg::t_entry             w_wdata;
    logic                         w_re;
    logic [ffha_pkg::ENTRY_W-1:0] w_rdata;
    ffha_pkg::t_entry             w_rd;
    ffha_pkg::t_entry             w_ent;
    logic                         w_fit;
    logic                         w_match;
    logic                         w_hit;
    logic                         w_split;
    logic                         w_scan_end;
    logic                         w_out_free;
    logic                         w_both_free;
    logic [ffha_pkg::RND_W-1:0]   w_size_rnd;
    logic [ffha_pkg::SIZE_W-1:0]  w_payload;
    logic [ffha_pkg::RND_W-1:0]   w_new_start;
    logic [ffha_pkg::SIZE_W-1:0]  w_new_bytes;

    assign w_rd = ffha_pkg::t_entry'(w_rdata);
    assign w_size_rnd = ({1'b0, i_request_size} + ALIGN) & ~ALIGN;

    assign w_fit   = w_rd.free && ({1'b0, w_rd.bytes} >= r_size);
    assign w_match = ({1'b0, w_rd.start} + HDR) == {1'b0, r_off};
    assign w_hit   = (i_cmd.phase == ffha_pkg::PH_SCAN) && r_chk_vld &&
                     ((r_cmd == ffha_pkg::CMD_ALLOC) ? w_fit : w_match);
    assign w_split = ({2'b00, w_rd.bytes} > ({1'b0, r_size} + SPLIT_ADD)) &&
                     (r_count < CNT_MAX);
    assign w_scan_end = !r_chk_vld && (r_rd >= r_count);
    assign w_out_free = !r_out_vld || i_out_ready;

    // merge view: the entry being freed counts as free
    always_comb begin
        w_ent = w_rd;
        if (r_chk_idx == r_hit_idx) begin
            w_ent.free = 1'b1;
        end
    end
    assign w_both_free = r_pend.free && w_ent.free;

    assign w_payload   = {1'b0, r_hit_ent.start} + HDR;
    assign w_new_start = {2'b00, r_hit_ent.start} + ffha_pkg::RND_W'(HDR) + r_size;
    assign w_new_bytes = r_hit_ent.bytes - r_size[ffha_pkg::SIZE_W-1:0] - HDR;

    always_comb begin
        w_re = 1'b0;
        case (i_cmd.phase)
            ffha_pkg::PH_SCAN:  w_re = !w_hit && (r_rd < r_count);
            ffha_pkg::PH_SHIFT: w_re = r_rd > {1'b0, r_hit_idx};
            ffha_pkg::PH_MERGE: w_re = r_rd < r_count;
            default:            w_re = 1'b0;
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_wr;
        w_wdata = r_pend;
        case (i_cmd.phase)
            ffha_pkg::PH_INIT: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = '{start: '0,
                            bytes: ffha_pkg::SIZE_W'(ffha_pkg::POOL_BYTES
                                                      - ffha_pkg::HEADER_BYTES),
                            free: 1'b1};
            end
            ffha_pkg::PH_SHIFT: begin
                w_we    = r_chk_vld;
                w_waddr = r_chk_idx + 1'b1;
                w_wdata = w_rd;
            end
            ffha_pkg::PH_ALLOC_WR: begin
                w_we    = 1'b1;
                w_waddr = r_hit_idx;
                w_wdata = '{start: r_hit_ent.start,
                            bytes: r_split ? r_size[ffha_pkg::SIZE_W-1:0] : r_hit_ent.bytes,
                            free: 1'b0};
            end
            ffha_pkg::PH_SPLIT_HI: begin
                w_we    = 1'b1;
                w_waddr = r_hit_idx + 1'b1;
                w_wdata = '{start: w_new_start[ffha_pkg::OFF_W-1:0],
                            bytes: w_new_bytes, free: 1'b1};
            end
            ffha_pkg::PH_MERGE: begin
                w_we = r_chk_vld && r_pend_vld && !w_both_free;
            end
            ffha_pkg::PH_MERGE_END: begin
                w_we = 1'b1;
            end
            default: w_we = 1'b0;
        endcase
    end

    ffha_ram #(
        .WIDTH(ffha_pkg::ENTRY_W),
        .DEPTH(ffha_pkg::MAX_BLOCKS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(r_rd[ffha_pkg::IDX_W-1:0]),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_count    <= ffha_pkg::CNT_W'(1);
            r_out_vld  <= 1'b0;
        end else begin
            r_chk_vld <= w_re;
            r_chk_idx <= r_rd[ffha_pkg::IDX_W-1:0];
            case (i_cmd.phase)
                ffha_pkg::PH_INIT: r_count <= ffha_pkg::CNT_W'(1);
                ffha_pkg::PH_IDLE: begin
                    if (i_accept) begin
                        r_cmd     <= i_command;
                        r_size    <= w_size_rnd;
                        r_off     <= i_free_offset;
                        r_rd      <= '0;
                        r_res_off <= '0;
                        r_res_status <= (i_command == ffha_pkg::CMD_ALLOC &&
                                         i_request_size == '0) ? ffha_pkg::ST_ZERO
                                                               : ffha_pkg::ST_DONE;
                    end
                end
                ffha_pkg::PH_SCAN: begin
                    if (w_re) begin
                        r_rd <= r_rd + 1'b1;
                    end
                    if (w_hit) begin
                        r_hit_idx  <= r_chk_idx;
                        r_hit_ent  <= w_rd;
                        r_split    <= w_split;
                        r_wr       <= '0;
                        r_pend_vld <= 1'b0;
                        r_rd <= (r_cmd == ffha_pkg::CMD_ALLOC) ? r_count - 1'b1 : '0;
                    end else if (w_scan_end) begin
                        r_res_status <= (r_cmd == ffha_pkg::CMD_ALLOC) ? ffha_pkg::ST_NO_FIT
                                                                        : ffha_pkg::ST_UNKNOWN;
                    end
                end
                ffha_pkg::PH_SHIFT: begin
                    if (w_re) begin
                        r_rd <= r_rd - 1'b1;
                    end
                end
                ffha_pkg::PH_ALLOC_WR: r_res_off <= w_payload[ffha_pkg::OFF_W-1:0];
                ffha_pkg::PH_SPLIT_HI: r_count <= r_count + 1'b1;
                ffha_pkg::PH_MERGE: begin
                    if (w_re) begin
                        r_rd <= r_rd + 1'b1;
                    end
                    if (r_chk_vld) begin
                        if (!r_pend_vld) begin
                            r_pend     <= w_ent;
                            r_pend_vld <= 1'b1;
                        end else if (w_both_free) begin
                            r_pend.bytes <= r_pend.bytes + w_ent.bytes + HDR;
                        end else begin
                            r_pend <= w_ent;
                            r_wr   <= r_wr + 1'b1;
                        end
                    end
                end
                ffha_pkg::PH_MERGE_END: r_count <= {1'b0, r_wr} + 1'b1;
                default: ;
            endcase
            if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cmd.phase == ffha_pkg::PH_RESULT && w_out_free) begin
                r_out_vld    <= 1'b1;
                r_out_status <= r_res_status;
                r_out_off    <= r_res_off;
            end
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_status        = r_out_status;
    assign o_result_offset = r_out_off;

    assign o_sts.req_zero  = (i_command == ffha_pkg::CMD_ALLOC) && (i_request_size == '0);
    assign o_sts.is_alloc  = (r_cmd == ffha_pkg::CMD_ALLOC);
    assign o_sts.hit       = w_hit;
    assign o_sts.split_now = w_split;
    assign o_sts.split     = r_split;
    assign o_sts.scan_end  = w_scan_end;
    assign o_sts.shift_end = !w_re && !r_chk_vld;
    assign o_sts.out_free  = w_out_free;
    assign o_sts.count     = r_count;
endmodule
